// ----- rtl/sb2da_pkg.sv -----
// ----------------------------------------------------------------------------
// sb2da_pkg
// Shared types, constants and the power-of-ten table used by the signed
// binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sb2da_pkg;

    localparam int VALUE_W = 32;              // width of the incoming integer
    localparam int CHAR_W  = 7;               // width of an ASCII character
    localparam int IDX_W   = 4;               // digit position, 0 .. MAX_IDX
    localparam int DIGIT_W = 4;               // one decimal digit
    localparam int TAB_W   = 35;              // holds 9 * 10^9 and 10^10
    localparam int QDEPTH  = 2;               // entries in the front/back queue
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [IDX_W-1:0]  MAX_IDX  = 4'd9;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;

    // One classified number waiting for the back end.
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
        logic [IDX_W-1:0]   top;    // position of the most significant digit
    } q_entry_t;

    // Handshake between queue and its two users.
    typedef struct packed {
        logic full;
        logic avail;
    } q_status_t;

    function automatic logic [TAB_W-1:0] pow10(input logic [IDX_W-1:0] k);
        logic [TAB_W-1:0] p;
        case (k)
            4'd0:    p = 35'd1;
            4'd1:    p = 35'd10;
            4'd2:    p = 35'd100;
            4'd3:    p = 35'd1000;
            4'd4:    p = 35'd10000;
            4'd5:    p = 35'd100000;
            4'd6:    p = 35'd1000000;
            4'd7:    p = 35'd10000000;
            4'd8:    p = 35'd100000000;
            4'd9:    p = 35'd1000000000;
            4'd10:   p = 35'd10000000000;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/sb2da_front.sv -----
// ----------------------------------------------------------------------------
// sb2da_front
// Takes each integer beat, forms sign and unsigned magnitude, counts the
// decimal digits and pushes the result into the queue.
// ----------------------------------------------------------------------------
module sb2da_front
    import sb2da_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      value_valid,
    output logic                      value_stall,
    input  q_status_t                 q_status,
    output logic                      push,
    output q_entry_t                  push_entry
);

    logic               hold_valid_reg;
    logic               hold_valid_next;
    logic [VALUE_W-1:0] raw_reg;
    logic               accept;
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [IDX_W-1:0]   top;

    assign push        = hold_valid_reg && !q_status.full;
    assign value_stall = hold_valid_reg && q_status.full;
    assign accept      = value_valid && !value_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    // Two's complement magnitude; the most negative value maps to 2^31.
    assign neg = raw_reg[VALUE_W-1];
    assign mag = neg ? (VALUE_W'(0) - raw_reg) : raw_reg;

    always_comb
    begin
        top = '0;
        for (int k = 1; k <= int'(MAX_IDX); k++)
        begin
            if ({(TAB_W - VALUE_W)'(0), mag} >= pow10(IDX_W'(k)))
            begin
                top = IDX_W'(k);
            end
        end
    end

    assign push_entry.neg = neg;
    assign push_entry.mag = mag;
    assign push_entry.top = top;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg <= value;
        end
    end

endmodule

// ----- rtl/sb2da_queue.sv -----
// ----------------------------------------------------------------------------
// sb2da_queue
// Short register queue between the classifying front end and the digit
// back end, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module sb2da_queue
    import sb2da_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output q_entry_t  head,
    output q_status_t status
);

    q_entry_t            slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.avail = (count_reg != '0);
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!status.full || pop))
        else $error("queue written while full");

    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> status.avail)
        else $error("queue read while empty");

endmodule

// ----- rtl/sb2da_back.sv -----
// ----------------------------------------------------------------------------
// sb2da_back
// Emits the characters of one queued number: an optional minus sign, then
// one decimal digit per beat, most significant first, by comparing the
// remainder against the multiples of the current power of ten.
// ----------------------------------------------------------------------------
module sb2da_back
    import sb2da_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_entry_t          head,
    input  q_status_t         q_status,
    output logic              pop,
    output logic [CHAR_W-1:0] ascii_char,
    output logic              last,
    output logic              char_valid,
    input  logic              char_stall
);

    logic               busy_reg;
    logic               busy_next;
    logic               neg_pend_reg;
    logic               neg_pend_next;
    logic [VALUE_W-1:0] mag_reg;
    logic [VALUE_W-1:0] mag_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CHAR_W-1:0]  char_reg;
    logic [CHAR_W-1:0]  char_next;
    logic               last_reg;
    logic               last_next;

    logic               out_free;
    logic [DIGIT_W-1:0] digit;
    logic [VALUE_W-1:0] rem;
    logic [TAB_W-1:0]   step;
    logic [TAB_W-1:0]   mul_tab [1:9];

    assign out_free = !out_valid_reg || !char_stall;
    assign step     = pow10(idx_reg);

    // Largest multiple of the current power of ten that fits gives the digit.
    always_comb
    begin
        digit = '0;
        rem   = mag_reg;
        for (int d = 1; d <= 9; d++)
        begin
            mul_tab[d] = TAB_W'(step * TAB_W'(d));
            if ({(TAB_W - VALUE_W)'(0), mag_reg} >= mul_tab[d])
            begin
                digit = DIGIT_W'(d);
                rem   = VALUE_W'({(TAB_W - VALUE_W)'(0), mag_reg} - mul_tab[d]);
            end
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        neg_pend_next  = neg_pend_reg;
        mag_next       = mag_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        pop            = 1'b0;

        if (out_valid_reg && !char_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (!busy_reg)
        begin
            if (q_status.avail)
            begin
                pop           = 1'b1;
                busy_next     = 1'b1;
                neg_pend_next = head.neg;
                mag_next      = head.mag;
                idx_next      = head.top;
            end
        end
        else if (out_free)
        begin
            out_valid_next = 1'b1;
            if (neg_pend_reg)
            begin
                char_next     = CH_MINUS;
                last_next     = 1'b0;
                neg_pend_next = 1'b0;
            end
            else
            begin
                char_next = CH_ZERO + CHAR_W'(digit);
                last_next = (idx_reg == '0);
                mag_next  = rem;
                if (idx_reg == '0)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            neg_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            neg_pend_reg  <= neg_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign ascii_char = char_reg;
    assign last       = last_reg;
    assign char_valid = out_valid_reg;

    // The remainder must always fit below the next power of ten.
    a_rem_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !neg_pend_reg) |->
            ({(TAB_W - VALUE_W)'(0), mag_reg} < pow10(idx_reg + 1'b1)))
        else $error("remainder exceeds current digit range");

    a_legal_char : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg == CH_MINUS ||
            (char_reg >= CH_ZERO && char_reg <= CH_ZERO + CHAR_W'(9))))
        else $error("illegal character emitted");

endmodule

// ----- rtl/signed_binary_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, one character per beat.
// ----------------------------------------------------------------------------
// Each integer beat becomes 1 to 11 character beats: a '-' for a negative
// value, then the decimal digits, most significant first, with last set on
// the final digit. Zero gives a single '0'; -2147483648 is converted exactly.
// A number is first loaded from the queue into the digit unit, which then
// resolves one decimal digit per cycle while char_stall does not hold its
// output. A two-entry queue between the classifying front end and the
// digit unit lets new integers be taken while earlier ones are still being
// printed.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii
    import sb2da_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      value_valid,
    output logic                      value_stall,
    output logic [CHAR_W-1:0]         ascii_char,
    output logic                      last,
    output logic                      char_valid,
    input  logic                      char_stall
);

    q_status_t q_status;
    q_entry_t  push_entry;
    q_entry_t  head;
    logic      push;
    logic      pop;

    sb2da_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .q_status    (q_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    sb2da_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    sb2da_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_status   (q_status),
        .pop        (pop),
        .ascii_char (ascii_char),
        .last       (last),
        .char_valid (char_valid),
        .char_stall (char_stall)
    );

endmodule
